@@ src/aesbe_pkg.sv @@
// Package for the AES block encrypt pipeline: types, S-box, GF helpers.
// No dependencies; used by aesbe_keysched and aes_block_encrypt.
package aesbe_pkg;

  localparam int unsigned KeyWordsDefault = 4;
  localparam int unsigned NumRegs = 4;
  localparam int unsigned AddrWidth = 5;

  typedef struct packed {
    logic [63:0] plain_hi;
    logic [63:0] plain_lo;
  } plain_t;

  typedef struct packed {
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
  } cipher_t;

  typedef enum logic [1:0] {
    REG_KEY_0 = 2'd0,
    REG_KEY_1 = 2'd1,
    REG_KEY_2 = 2'd2,
    REG_KEY_3 = 2'd3
  } reg_idx_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [16] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,
    8'h1b,8'h36,8'h6c,8'hd8,8'hab,8'h4d,8'h9a,8'h2f
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // State as 128 bits, byte 0 at [127:120]; byte index r + 4*c.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8*(r + 4*c) -: 8] = SBOX[s[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32*c -: 8];
      a1 = s[119 - 32*c -: 8];
      a2 = s[111 - 32*c -: 8];
      a3 = s[103 - 32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                             a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
    end
    mix_columns = t;
  endfunction

endpackage

@@ src/aesbe_keysched.sv @@
// Key schedule expander: one word per cycle after reset and after each key write.
// Depends on aesbe_pkg.
module aesbe_keysched import aesbe_pkg::*; #(
  parameter int unsigned KeyWords = KeyWordsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [255:0] key_i,
  output logic        busy_o,
  output logic [32*4*(KeyWords+7)-1:0] rk_o
);
  localparam int unsigned SchedWords = 4 * (KeyWords + 7);
  localparam int unsigned CntW = $clog2(SchedWords + 1);
  localparam int unsigned ModW = $clog2(KeyWords + 1);

  logic [31:0]     w_q [SchedWords];
  logic [CntW-1:0] cnt_q;
  logic [ModW-1:0] modk_q;
  logic [3:0]      rc_q;
  logic            busy_q;
  logic [31:0]     prev, t;

  // Newest word sits at the top; shift the schedule down one word per step.
  always_comb begin
    prev = w_q[SchedWords-1];
    t = prev;
    if (modk_q == '0) begin
      t = sub_word({prev[23:0], prev[31:24]}) ^ {RCON[rc_q], 24'h0};
    end else if (KeyWords > 6 && modk_q == ModW'(4)) begin
      t = sub_word(prev);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(SchedWords - KeyWords);
      modk_q <= '0;
      rc_q   <= '0;
      for (int i = 0; i < SchedWords; i++) w_q[i] <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(SchedWords - KeyWords);
      modk_q <= '0;
      rc_q   <= '0;
      for (int i = 0; i < KeyWords; i++) begin
        w_q[SchedWords - KeyWords + i] <= key_i[255 - 32*i -: 32];
      end
    end else if (busy_q) begin
      for (int i = 0; i < SchedWords - 1; i++) w_q[i] <= w_q[i+1];
      w_q[SchedWords-1] <= w_q[SchedWords-KeyWords] ^ t;
      if (modk_q == ModW'(KeyWords - 1)) begin
        modk_q <= '0;
      end else begin
        modk_q <= modk_q + ModW'(1);
      end
      if (modk_q == '0) rc_q <= rc_q + 4'd1;
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) busy_q <= 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < SchedWords; i++) rk_o[32*(SchedWords-i)-1 -: 32] = w_q[i];
  end
  assign busy_o = busy_q;
endmodule

@@ src/aes_block_encrypt.sv @@
// AES forward cipher top level: APB key registers and a round pipeline.
// Depends on aesbe_pkg and aesbe_keysched.
//
// Usage:
//   Plaintext beats enter on in_valid_i/in_stall_o carrying plain_t; ciphertext
//   beats leave on out_valid_o/out_stall_i carrying cipher_t.
//   The key lives in four 64-bit APB registers at byte addresses 0, 8, 16, 24.
//   Each key write re-expands the schedule, one word a cycle, producing
//   4*(KeyWords+7)-KeyWords words (40 for AES-128); input is held off
//   (in_stall_o high) while that runs, and also after reset
//   (expansion of the all-zero key).
//   Pipeline: one register stage for the initial AddRoundKey, then one stage
//   per round, KeyWords+6 rounds.
//   Throughput: one block every cycle while the output is not stalled and no key expansion runs.
//   When the receiver stalls a valid output beat, every stage holds (global
//   enable); nothing is dropped or repeated. Reset clears all valid bits.
module aes_block_encrypt import aesbe_pkg::*; #(
  parameter int unsigned KeyWords = KeyWordsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  plain_t               in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cipher_t              out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);
  localparam int unsigned Rounds = KeyWords + 6;
  localparam int unsigned SchedWords = 4 * (Rounds + 1);
  localparam int unsigned Stages = Rounds + 1;

  logic [63:0] key_q [NumRegs];
  logic        wr_en, ks_busy, adv;
  logic [32*SchedWords-1:0] rk;
  logic [127:0] st_q [Stages];
  logic         v_q  [Stages];
  reg_idx_e     ridx;

  // Key registers.
  assign pready = 1'b1;
  assign ridx   = reg_idx_e'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite && (paddr[2:0] == 3'd0);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) key_q[i] <= '0;
    end else if (wr_en) begin
      key_q[ridx] <= pwdata;
    end
  end
  always_comb begin
    case (ridx)
      REG_KEY_0: prdata = key_q[0];
      REG_KEY_1: prdata = key_q[1];
      REG_KEY_2: prdata = key_q[2];
      REG_KEY_3: prdata = key_q[3];
      default:   prdata = '0;
    endcase
  end

  aesbe_keysched #(.KeyWords(KeyWords)) u_ks (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(wr_en),
    .key_i  ({key_q[0], key_q[1], key_q[2], key_q[3]} ^
             (ridx == REG_KEY_0 ? {pwdata ^ key_q[0], 192'h0} :
              ridx == REG_KEY_1 ? {64'h0, pwdata ^ key_q[1], 128'h0} :
              ridx == REG_KEY_2 ? {128'h0, pwdata ^ key_q[2], 64'h0} :
                                  {192'h0, pwdata ^ key_q[3]})),
    .busy_o (ks_busy),
    .rk_o   (rk)
  );

  // Advance the whole pipe unless the output is stalled with a valid beat.
  assign adv        = !(v_q[Stages-1] && out_stall_i);
  assign in_stall_o = !adv || ks_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Stages; i++) v_q[i] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= in_valid_i && !ks_busy;
      for (int i = 1; i < Stages; i++) v_q[i] <= v_q[i-1];
    end
  end

  // Stage 0: whitening; stage r: full round r, last stage drops MixColumns.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= {in_data_i.plain_hi, in_data_i.plain_lo} ^ rk[32*SchedWords-1 -: 128];
      for (int r = 1; r < Stages; r++) begin
        if (r == Rounds) begin
          st_q[r] <= sub_shift(st_q[r-1]) ^ rk[32*SchedWords-1-128*r -: 128];
        end else begin
          st_q[r] <= mix_columns(sub_shift(st_q[r-1])) ^
                     rk[32*SchedWords-1-128*r -: 128];
        end
      end
    end
  end

  assign out_valid_o          = v_q[Stages-1];
  assign out_data_o.cipher_hi = st_q[Stages-1][127:64];
  assign out_data_o.cipher_lo = st_q[Stages-1][63:0];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed under stall");
  a_noacc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ks_busy |-> in_stall_o)
    else $error("input accepted during key expansion");
  a_stall_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v_q[0]))
    else $error("first stage moved while pipe held");
endmodule
